// ----- src/kpwq_pkg.sv -----
// ----------------------------------------------------------------------------
// kpwq_pkg
// Types, codes and helpers shared by the keyed priority wait queue.
// ----------------------------------------------------------------------------
package kpwq_pkg;

   // action codes of a request beat
   localparam logic [2:0] ACT_ENQUEUE  = 3'd0;
   localparam logic [2:0] ACT_DEQUEUE  = 3'd1;
   localparam logic [2:0] ACT_CANCEL   = 3'd2;
   localparam logic [2:0] ACT_POSITION = 3'd3;
   localparam logic [2:0] ACT_EXPIRE   = 3'd4;
   localparam logic [2:0] ACT_COUNT    = 3'd5;

   // status codes of a response beat
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]  MAX_RESULTS   = 6'd32;

   // one slot of the shared pool
   typedef struct packed {
      logic [15:0] key;
      logic [15:0] user;
      logic [7:0]  urgency;
      logic [31:0] stamp;
      logic [5:0]  place;
   } entry_type;

   // write command into the slot memory
   typedef struct packed {
      logic      en;
      entry_type data;
   } slot_wr_type;

   // write command into the new-place memory
   typedef struct packed {
      logic       en;
      logic [5:0] place;
   } place_wr_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  amount;
      logic [15:0] out_key;
      logic [15:0] served_user;
      logic        last;
   } rsp_type;

   // true when a is served ahead of b (places of one line are distinct)
   function automatic logic serves_first(entry_type a, entry_type b);
      logic r;
      if (a.urgency != b.urgency) begin
         r = a.urgency > b.urgency;
      end else if (a.stamp != b.stamp) begin
         r = a.stamp < b.stamp;
      end else begin
         r = a.place < b.place;
      end
      return r;
   endfunction

   function automatic rsp_type mk_rsp(logic [1:0] status, logic [6:0] amount,
                                      logic [15:0] out_key, logic [15:0] user,
                                      logic last);
      rsp_type r;
      r.status      = status;
      r.amount      = amount;
      r.out_key     = out_key;
      r.served_user = user;
      r.last        = last;
      return r;
   endfunction

endpackage

// ----- src/kpwq_if.sv -----
// ----------------------------------------------------------------------------
// kpwq_req_if / kpwq_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface kpwq_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] queue_key;
   logic [15:0] requester;
   logic [7:0]  urgency;
   logic [31:0] current_time;
   logic [15:0] timeout_hours;

   modport source (output valid, action, queue_key, requester, urgency,
                   current_time, timeout_hours, input ready);
   modport sink (input valid, action, queue_key, requester, urgency,
                 current_time, timeout_hours, output ready);
endinterface

interface kpwq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [6:0]  amount;
   logic [15:0] out_key;
   logic [15:0] served_user;
   logic        last;

   modport source (output valid, status, amount, out_key, served_user, last,
                   input ready);
   modport sink (input valid, status, amount, out_key, served_user, last,
                 output ready);
endinterface

// ----- src/kpwq_store.sv -----
// ----------------------------------------------------------------------------
// kpwq_store
// Slot memory and new-place memory, one write and one registered read each.
// ----------------------------------------------------------------------------
module kpwq_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                   clock,
   input  kpwq_pkg::slot_wr_type  slot_wr,
   input  logic [AW-1:0]          slot_wr_addr,
   input  kpwq_pkg::place_wr_type place_wr,
   input  logic [AW-1:0]          place_wr_addr,
   input  logic [AW-1:0]          rd_addr,
   output kpwq_pkg::entry_type    slot_rd,
   output logic [5:0]             place_rd
);
   import kpwq_pkg::*;

   entry_type  slot_mem [DEPTH];
   logic [5:0] place_mem [DEPTH];

   // write the slot and read one address a cycle
   always_ff @(posedge clock) begin
      if (slot_wr.en) begin
         slot_mem[slot_wr_addr] <= slot_wr.data;
      end
      slot_rd <= slot_mem[rd_addr];
   end

   // hold the ranks computed for a re-line
   always_ff @(posedge clock) begin
      if (place_wr.en) begin
         place_mem[place_wr_addr] <= place_wr.place;
      end
      place_rd <= place_mem[rd_addr];
   end

endmodule

// ----- src/keyed_priority_wait_queue.sv -----
// ----------------------------------------------------------------------------
// keyed_priority_wait_queue
// Shared pool of waiting entries with per-key lines, served by urgency.
// ----------------------------------------------------------------------------
// One request at a time. Every request sweeps the slot memory once through
// its single read port; enqueue, position, count and a missed cancel or
// dequeue take no more. A cancel adds one re-line sweep. A dequeue ranks
// every entry of the line against every slot, which is longest when the
// whole pool waits on one key. An expire sweep spends a pick sweep and a
// re-line sweep for each removed entry, plus a closing pick sweep when
// fewer than 32 go, and emits one response beat per removed entry (at most
// 32), the final one marked last, or a single miss beat when none expires.
// Response stalls can lengthen any request. The response is registered, so
// a waiting beat holds while the next request is taken.
module keyed_priority_wait_queue #(
   parameter int POOL_ENTRIES = 32
) (
   input  logic       clock,
   input  logic       reset,
   kpwq_req_if.sink   req_ch,
   kpwq_rsp_if.source rsp_ch
);
   import kpwq_pkg::*;

   localparam int N  = POOL_ENTRIES;
   localparam int IW = $clog2(N);
   localparam int CW = $clog2(N + 1);
   localparam logic [IW-1:0] LAST = IW'(N - 1);
   localparam logic [CW-1:0] CNT_END = CW'(N);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_SCAN, S_DECIDE, S_SHIFT, S_PICK, S_PGOT,
      S_RLOAD, S_RREF, S_RSWEEP, S_COPY, S_FIN
   } state_type;

   state_type     state_ff;
   logic [N-1:0]  valid_ff;
   logic [N-1:0]  old_ff;
   logic [2:0]    op_ff;
   logic [15:0]   key_ff;
   logic [15:0]   user_ff;
   logic [7:0]    urg_ff;
   logic [31:0]   now_ff;
   logic [27:0]   prod_ff;
   logic [31:0]   cut_ff;
   logic          neg_ff;
   logic [CW-1:0] cnt_ff;
   logic          s1_ff;
   logic [IW-1:0] s1_idx_ff;
   logic          found_ff;
   logic [IW-1:0] hit_idx_ff;
   logic [5:0]    hit_place_ff;
   logic [6:0]    len_ff;
   logic          free_ok_ff;
   logic [IW-1:0] free_idx_ff;
   logic          best_ok_ff;
   entry_type     best_ff;
   logic [IW-1:0] best_idx_ff;
   logic          pick_ok_ff;
   entry_type     pick_ff;
   logic [IW-1:0] pick_idx_ff;
   logic          pend_ok_ff;
   logic [15:0]   pend_key_ff;
   logic [15:0]   pend_user_ff;
   logic [5:0]    pcount_ff;
   logic [15:0]   sk_ff;
   logic [5:0]    sp_ff;
   logic [IW-1:0] i_ff;
   entry_type     ref_ff;
   logic [5:0]    rank_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   entry_type     rd;
   logic [5:0]    np_rd;
   logic [IW-1:0] rd_addr;
   slot_wr_type   slot_wr;
   logic [IW-1:0] slot_wr_addr;
   place_wr_type  place_wr;
   logic          sweep_on;
   logic          sweep_done;
   logic          out_free;
   logic          inl;
   logic [15:0]   cmp_key;
   logic [5:0]    rank_in;

   kpwq_store #(.DEPTH(N), .AW(IW)) u_store (
      .clock        (clock),
      .slot_wr      (slot_wr),
      .slot_wr_addr (slot_wr_addr),
      .place_wr     (place_wr),
      .place_wr_addr(i_ff),
      .rd_addr      (rd_addr),
      .slot_rd      (rd),
      .place_rd     (np_rd)
   );

   // decode the sweep and the entry under inspection
   always_comb begin
      sweep_on   = (state_ff == S_SCAN) || (state_ff == S_SHIFT) ||
                   (state_ff == S_PICK) || (state_ff == S_RSWEEP) ||
                   (state_ff == S_COPY);
      sweep_done = s1_ff && (s1_idx_ff == LAST);
      rd_addr    = (state_ff == S_RLOAD) ? i_ff : cnt_ff[IW-1:0];
      cmp_key    = (state_ff == S_SHIFT) ? sk_ff : key_ff;
      inl        = valid_ff[s1_idx_ff] && (rd.key == cmp_key);
      out_free   = !rsp_valid_ff || rsp_ch.ready;
      rank_in    = rank_ff + 6'((s1_ff && inl && (s1_idx_ff != i_ff) &&
                                 serves_first(rd, ref_ff)) ? 1 : 0);
   end

   // drive the memory writes
   always_comb begin
      slot_wr.en     = 1'b0;
      slot_wr.data   = rd;
      slot_wr_addr   = s1_idx_ff;
      place_wr.en    = (state_ff == S_RSWEEP) && sweep_done;
      place_wr.place = rank_in;
      case (state_ff)
         S_DECIDE: begin
            slot_wr.en = (op_ff == ACT_ENQUEUE) && out_free && !found_ff && free_ok_ff;
            slot_wr.data.key     = key_ff;
            slot_wr.data.user    = user_ff;
            slot_wr.data.urgency = urg_ff;
            slot_wr.data.stamp   = now_ff;
            slot_wr.data.place   = len_ff[5:0];
            slot_wr_addr = free_idx_ff;
         end
         S_SHIFT: begin
            slot_wr.en = s1_ff && inl && (rd.place > sp_ff);
            slot_wr.data.place = rd.place - 6'd1;
         end
         S_COPY: begin
            slot_wr.en = s1_ff && inl;
            slot_wr.data.place = np_rd;
         end
         default: begin
            slot_wr.en = 1'b0;
         end
      endcase
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_ff.status;
   assign rsp_ch.amount      = rsp_ff.amount;
   assign rsp_ch.out_key     = rsp_ff.out_key;
   assign rsp_ch.served_user = rsp_ff.served_user;
   assign rsp_ch.last        = rsp_ff.last;

   // sequence the request through its sweeps
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         old_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         s1_ff        <= 1'b0;
         cnt_ff       <= '0;
         pcount_ff    <= '0;
      end else begin
         if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // advance the read pointer of a sweep
         if (sweep_on) begin
            if (cnt_ff != CNT_END) begin
               cnt_ff    <= cnt_ff + CW'(1);
               s1_ff     <= 1'b1;
               s1_idx_ff <= cnt_ff[IW-1:0];
            end else begin
               s1_ff <= 1'b0;
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid && (req_ch.action <= ACT_COUNT)) begin
                  op_ff    <= req_ch.action;
                  key_ff   <= req_ch.queue_key;
                  user_ff  <= req_ch.requester;
                  urg_ff   <= req_ch.urgency;
                  now_ff   <= req_ch.current_time;
                  prod_ff  <= 28'(req_ch.timeout_hours) * 28'(SECS_PER_HOUR);
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               neg_ff     <= now_ff < 32'(prod_ff);
               cut_ff     <= now_ff - 32'(prod_ff);
               found_ff   <= 1'b0;
               free_ok_ff <= 1'b0;
               best_ok_ff <= 1'b0;
               len_ff     <= '0;
               cnt_ff     <= '0;
               s1_ff      <= 1'b0;
               state_ff   <= S_SCAN;
            end
            S_SCAN: begin
               if (s1_ff) begin
                  if (!valid_ff[s1_idx_ff] && !free_ok_ff) begin
                     free_ok_ff  <= 1'b1;
                     free_idx_ff <= s1_idx_ff;
                  end
                  if (inl) begin
                     len_ff <= len_ff + 7'd1;
                     if (rd.user == user_ff) begin
                        found_ff     <= 1'b1;
                        hit_idx_ff   <= s1_idx_ff;
                        hit_place_ff <= rd.place;
                     end
                     if (!best_ok_ff || serves_first(rd, best_ff)) begin
                        best_ok_ff  <= 1'b1;
                        best_ff     <= rd;
                        best_idx_ff <= s1_idx_ff;
                     end
                  end
                  old_ff[s1_idx_ff] <= valid_ff[s1_idx_ff] && !neg_ff &&
                                       (rd.stamp < cut_ff);
                  if (sweep_done) begin
                     state_ff <= S_DECIDE;
                  end
               end
            end
            S_DECIDE: begin
               case (op_ff)
                  ACT_ENQUEUE: begin
                     if (out_free) begin
                        rsp_valid_ff <= 1'b1;
                        if (found_ff) begin
                           rsp_ff <= mk_rsp(ST_DUP, 7'd0, 16'd0, 16'd0, 1'b1);
                        end else if (!free_ok_ff) begin
                           rsp_ff <= mk_rsp(ST_FULL, 7'd0, 16'd0, 16'd0, 1'b1);
                        end else begin
                           rsp_ff <= mk_rsp(ST_OK, len_ff + 7'd1, 16'd0, 16'd0, 1'b1);
                           valid_ff[free_idx_ff] <= 1'b1;
                        end
                        state_ff <= S_IDLE;
                     end
                  end
                  ACT_DEQUEUE: begin
                     if (!best_ok_ff) begin
                        if (out_free) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff   <= mk_rsp(ST_MISS, 7'd0, 16'd0, 16'd0, 1'b1);
                           state_ff <= S_IDLE;
                        end
                     end else begin
                        valid_ff[best_idx_ff] <= 1'b0;
                        i_ff     <= '0;
                        state_ff <= S_RLOAD;
                     end
                  end
                  ACT_CANCEL: begin
                     if (!found_ff) begin
                        if (out_free) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff   <= mk_rsp(ST_MISS, 7'd0, 16'd0, 16'd0, 1'b1);
                           state_ff <= S_IDLE;
                        end
                     end else begin
                        valid_ff[hit_idx_ff] <= 1'b0;
                        sk_ff    <= key_ff;
                        sp_ff    <= hit_place_ff;
                        cnt_ff   <= '0;
                        s1_ff    <= 1'b0;
                        state_ff <= S_SHIFT;
                     end
                  end
                  ACT_POSITION: begin
                     if (out_free) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff <= found_ff ?
                           mk_rsp(ST_OK, 7'(hit_place_ff) + 7'd1, 16'd0, 16'd0, 1'b1) :
                           mk_rsp(ST_MISS, 7'd0, 16'd0, 16'd0, 1'b1);
                        state_ff <= S_IDLE;
                     end
                  end
                  ACT_COUNT: begin
                     if (out_free) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff   <= mk_rsp(ST_OK, len_ff, 16'd0, 16'd0, 1'b1);
                        state_ff <= S_IDLE;
                     end
                  end
                  ACT_EXPIRE: begin
                     pcount_ff  <= '0;
                     pend_ok_ff <= 1'b0;
                     pick_ok_ff <= 1'b0;
                     cnt_ff     <= '0;
                     s1_ff      <= 1'b0;
                     state_ff   <= S_PICK;
                  end
                  default: begin
                     state_ff <= S_IDLE;
                  end
               endcase
            end
            S_PICK: begin
               if (s1_ff) begin
                  // take the smallest key, then the smallest place
                  if (old_ff[s1_idx_ff] && (!pick_ok_ff || (rd.key < pick_ff.key) ||
                      ((rd.key == pick_ff.key) && (rd.place < pick_ff.place)))) begin
                     pick_ok_ff  <= 1'b1;
                     pick_ff     <= rd;
                     pick_idx_ff <= s1_idx_ff;
                  end
                  if (sweep_done) begin
                     state_ff <= (pick_ok_ff || old_ff[s1_idx_ff]) ? S_PGOT : S_FIN;
                  end
               end
            end
            S_PGOT: begin
               if (!pend_ok_ff || out_free) begin
                  if (pend_ok_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff <= mk_rsp(ST_OK, 7'd0, pend_key_ff, pend_user_ff, 1'b0);
                  end
                  pend_ok_ff   <= 1'b1;
                  pend_key_ff  <= pick_ff.key;
                  pend_user_ff <= pick_ff.user;
                  old_ff[pick_idx_ff]   <= 1'b0;
                  valid_ff[pick_idx_ff] <= 1'b0;
                  pcount_ff <= pcount_ff + 6'd1;
                  sk_ff     <= pick_ff.key;
                  sp_ff     <= pick_ff.place;
                  cnt_ff    <= '0;
                  s1_ff     <= 1'b0;
                  state_ff  <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (sweep_done) begin
                  if ((op_ff == ACT_EXPIRE) && (pcount_ff != MAX_RESULTS)) begin
                     pick_ok_ff <= 1'b0;
                     cnt_ff     <= '0;
                     s1_ff      <= 1'b0;
                     state_ff   <= S_PICK;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end
            end
            S_RLOAD: begin
               if (!valid_ff[i_ff]) begin
                  if (i_ff == LAST) begin
                     cnt_ff   <= '0;
                     s1_ff    <= 1'b0;
                     state_ff <= S_COPY;
                  end else begin
                     i_ff <= i_ff + IW'(1);
                  end
               end else begin
                  state_ff <= S_RREF;
               end
            end
            S_RREF: begin
               ref_ff <= rd;
               if (rd.key == key_ff) begin
                  rank_ff  <= '0;
                  cnt_ff   <= '0;
                  s1_ff    <= 1'b0;
                  state_ff <= S_RSWEEP;
               end else if (i_ff == LAST) begin
                  cnt_ff   <= '0;
                  s1_ff    <= 1'b0;
                  state_ff <= S_COPY;
               end else begin
                  i_ff     <= i_ff + IW'(1);
                  state_ff <= S_RLOAD;
               end
            end
            S_RSWEEP: begin
               // count the entries of the line served ahead of the reference
               rank_ff <= rank_in;
               if (sweep_done) begin
                  if (i_ff == LAST) begin
                     cnt_ff   <= '0;
                     s1_ff    <= 1'b0;
                     state_ff <= S_COPY;
                  end else begin
                     i_ff     <= i_ff + IW'(1);
                     state_ff <= S_RLOAD;
                  end
               end
            end
            S_COPY: begin
               if (sweep_done) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  case (op_ff)
                     ACT_DEQUEUE: rsp_ff <= mk_rsp(ST_OK, 7'd0, 16'd0, best_ff.user, 1'b1);
                     ACT_EXPIRE: begin
                        rsp_ff <= pend_ok_ff ?
                           mk_rsp(ST_OK, 7'd0, pend_key_ff, pend_user_ff, 1'b1) :
                           mk_rsp(ST_MISS, 7'd0, 16'd0, 16'd0, 1'b1);
                     end
                     default: rsp_ff <= mk_rsp(ST_OK, 7'd0, 16'd0, 16'd0, 1'b1);
                  endcase
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_enq_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) && slot_wr.en |=> valid_ff[$past(slot_wr_addr)])
      else $error("enqueued slot not marked valid");

   a_deq_drops_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) && (op_ff == ACT_DEQUEUE) && best_ok_ff
      |=> $countones(valid_ff) == $past($countones(valid_ff)) - 1)
      else $error("dequeue did not remove exactly one entry");

   a_expire_bound: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= MAX_RESULTS || state_ff == S_IDLE)
      else $error("expire removed too many entries");

   a_rank_ref_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RSWEEP) |-> valid_ff[i_ff])
      else $error("ranking against an empty slot");
`endif

endmodule

// ----- verif/kpwq_tb_if.sv -----
// ----------------------------------------------------------------------------
// kpwq_tb_if
// Bundled request and response channels used by the wait queue testbench.
// ----------------------------------------------------------------------------
// The block's own interfaces live in src/kpwq_if.sv; this file only groups
// the two channel instances so the testbench can hand them around as one.
interface kpwq_tb_if;
   kpwq_req_if req_ch ();
   kpwq_rsp_if rsp_ch ();
endinterface

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives request beats into the keyed priority wait queue, mirrors the pool
// in a scoreboard and checks every response beat field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
   import kpwq_pkg::*;

   localparam int IDLE_LIMIT = 400000;

   // action codes outside the defined set, ignored by the block
   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;

   class wait_pool_board;
      bit          used [32];
      bit [15:0]   key [32];
      bit [15:0]   user [32];
      bit [7:0]    urg [32];
      bit [31:0]   stamp [32];
      bit [5:0]    place [32];
      rsp_type     pending [$];
      int          errors;

      // append one expected response beat
      function void queue_rsp(bit [1:0] st, bit [6:0] amt, bit [15:0] k,
                              bit [15:0] u, bit l);
         pending = {pending, mk_rsp(st, amt, k, u, l)};
      endfunction

      function bit ahead(int a, int b);
         if (urg[a] != urg[b]) return urg[a] > urg[b];
         if (stamp[a] != stamp[b]) return stamp[a] < stamp[b];
         if (place[a] != place[b]) return place[a] < place[b];
         return a < b;
      endfunction

      function bit member(int i, bit [15:0] k);
         return used[i] && key[i] == k;
      endfunction

      function int line_len(bit [15:0] k);
         int n;
         n = 0;
         for (int i = 0; i < 32; i++) if (member(i, k)) n++;
         return n;
      endfunction

      function int find(bit [15:0] k, bit [15:0] u);
         for (int i = 0; i < 32; i++) if (member(i, k) && user[i] == u) return i;
         return -1;
      endfunction

      // renumber a line, by service order or by old place
      function void reline(bit [15:0] k, bit by_service);
         bit [5:0] np [32];
         int n;
         for (int i = 0; i < 32; i++) begin
            if (!member(i, k)) continue;
            n = 0;
            for (int j = 0; j < 32; j++) begin
               if (j == i || !member(j, k)) continue;
               if (by_service ? ahead(j, i)
                              : (place[j] < place[i] || (place[j] == place[i] && j < i)))
                  n++;
            end
            np[i] = n[5:0];
         end
         for (int i = 0; i < 32; i++) if (member(i, k)) place[i] = np[i];
      endfunction

      function void note_request(bit [2:0] act, bit [15:0] k, bit [15:0] u, bit [7:0] ur,
                                 bit [31:0] now, bit [15:0] hrs);
         int s, n, pick, cnt;
         bit old [32];
         longint cutoff;
         case (act)
            ACT_ENQUEUE: begin
               s = -1;
               if (find(k, u) >= 0) begin
                  queue_rsp(ST_DUP, 7'd0, 16'd0, 16'd0, 1'b1);
                  return;
               end
               for (int i = 0; i < 32 && s < 0; i++) if (!used[i]) s = i;
               if (s < 0) begin
                  queue_rsp(ST_FULL, 7'd0, 16'd0, 16'd0, 1'b1);
                  return;
               end
               n = line_len(k);
               used[s] = 1; key[s] = k; user[s] = u; urg[s] = ur; stamp[s] = now;
               place[s] = n[5:0];
               queue_rsp(ST_OK, 7'(n + 1), 16'd0, 16'd0, 1'b1);
            end
            ACT_DEQUEUE: begin
               s = -1;
               for (int i = 0; i < 32; i++)
                  if (member(i, k) && (s < 0 || ahead(i, s))) s = i;
               if (s < 0) begin
                  queue_rsp(ST_MISS, 7'd0, 16'd0, 16'd0, 1'b1);
                  return;
               end
               used[s] = 0;
               reline(k, 1'b1);
               queue_rsp(ST_OK, 7'd0, 16'd0, user[s], 1'b1);
            end
            ACT_CANCEL: begin
               s = find(k, u);
               if (s >= 0) begin
                  used[s] = 0;
                  reline(k, 1'b0);
               end
               queue_rsp(s >= 0 ? ST_OK : ST_MISS, 7'd0, 16'd0, 16'd0, 1'b1);
            end
            ACT_POSITION: begin
               s = find(k, u);
               if (s < 0) queue_rsp(ST_MISS, 7'd0, 16'd0, 16'd0, 1'b1);
               else queue_rsp(ST_OK, 7'(place[s] + 1), 16'd0, 16'd0, 1'b1);
            end
            ACT_EXPIRE: begin
               cutoff = longint'(now) - longint'(hrs) * 3600;
               cnt = 0;
               for (int i = 0; i < 32; i++) old[i] = used[i] && longint'(stamp[i]) < cutoff;
               while (cnt < 32) begin
                  pick = -1;
                  for (int j = 0; j < 32; j++) begin
                     if (!old[j]) continue;
                     if (pick < 0 || key[j] < key[pick] ||
                         (key[j] == key[pick] && place[j] < place[pick]))
                        pick = j;
                  end
                  if (pick < 0) break;
                  old[pick] = 0;
                  used[pick] = 0;
                  queue_rsp(ST_OK, 7'd0, key[pick], user[pick], 1'b0);
                  reline(key[pick], 1'b0);
                  cnt++;
               end
               if (cnt == 0) queue_rsp(ST_MISS, 7'd0, 16'd0, 16'd0, 1'b1);
               else pending[$].last = 1'b1;
            end
            ACT_COUNT: queue_rsp(ST_OK, 7'(line_len(k)), 16'd0, 16'd0, 1'b1);
            default: ;
         endcase
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (pending.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status != exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
         end
         if (got.amount != exp.amount) begin
            $error("amount: expected %0d, got %0d", exp.amount, got.amount); errors++;
         end
         if (got.out_key != exp.out_key) begin
            $error("out_key: expected %0h, got %0h", exp.out_key, got.out_key); errors++;
         end
         if (got.served_user != exp.served_user) begin
            $error("served_user: expected %0h, got %0h", exp.served_user,
                   got.served_user);
            errors++;
         end
         if (got.last != exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last); errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   kpwq_tb_if bus ();
   wait_pool_board board;
   bit  calm;
   int  idle_cycles;
   bit [31:0] clock_now;

   keyed_priority_wait_queue u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (bus.req_ch),
      .rsp_ch (bus.rsp_ch)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // randomly stall the response side, except in calm stretches
   always @(posedge clock) begin
      if (reset) begin
         bus.rsp_ch.ready <= 1'b0;
      end else begin
         bus.rsp_ch.ready <= calm || ($urandom_range(99) >= 37);
      end
   end

   // check every response beat
   always @(posedge clock) begin
      if (!reset && bus.rsp_ch.valid && bus.rsp_ch.ready)
         board.check_response(mk_rsp(bus.rsp_ch.status, bus.rsp_ch.amount,
                                     bus.rsp_ch.out_key, bus.rsp_ch.served_user,
                                     bus.rsp_ch.last));
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (bus.req_ch.valid && bus.req_ch.ready) ||
          (bus.rsp_ch.valid && bus.rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   // send one request beat and hold it until accepted; valid stays high
   // afterwards until the next beat, an idle cycle or a drain drops it
   task automatic send(bit [2:0] act, bit [15:0] k, bit [15:0] u, bit [7:0] ur,
                       bit [31:0] now, bit [15:0] hrs);
      while (!calm && $urandom_range(99) < 37) begin
         bus.req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      bus.req_ch.valid         <= 1'b1;
      bus.req_ch.action        <= act;
      bus.req_ch.queue_key     <= k;
      bus.req_ch.requester     <= u;
      bus.req_ch.urgency       <= ur;
      bus.req_ch.current_time  <= now;
      bus.req_ch.timeout_hours <= hrs;
      do @(posedge clock); while (!bus.req_ch.ready);
      board.note_request(act, k, u, ur, now, hrs);
   endtask

   // drop valid and wait for every expected beat
   task automatic drain();
      bus.req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
   endtask

   // mostly a few keys and users so lines actually build up
   task automatic random_item();
      bit [2:0] act;
      bit [15:0] k, u, hrs;
      int pick;
      pick = $urandom_range(99);
      act = pick < 35 ? ACT_ENQUEUE : pick < 55 ? ACT_DEQUEUE : pick < 67 ? ACT_CANCEL :
            pick < 79 ? ACT_POSITION : pick < 85 ? ACT_EXPIRE : pick < 95 ? ACT_COUNT :
            3'($urandom_range(7));
      k = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(3)) << 14;
      u = $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(7));
      hrs = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(2));
      clock_now = clock_now + $urandom_range(4000);
      send(act, k, u, $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(2)),
           $urandom_range(19) == 0 ? $urandom : clock_now, hrs);
   endtask

   initial begin
      board = new();
      calm = 0;
      clock_now = 32'd100000;
      reset = 1'b1;
      bus.req_ch.valid <= 1'b0;
      bus.req_ch.action <= ACT_COUNT;
      bus.req_ch.queue_key <= '0;
      bus.req_ch.requester <= '0;
      bus.req_ch.urgency <= '0;
      bus.req_ch.current_time <= '0;
      bus.req_ch.timeout_hours <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: misses on an empty pool, extremes, ties and duplicates
      send(ACT_DEQUEUE, 16'h0000, '0, '0, '0, '0);
      send(ACT_CANCEL, 16'hFFFF, 16'hFFFF, '0, '0, '0);
      send(ACT_POSITION, 16'h0001, 16'h0001, '0, '0, '0);
      send(ACT_COUNT, 16'hFFFF, '0, '0, '0, '0);
      send(ACT_EXPIRE, '0, '0, '0, 32'hFFFF_FFFF, 16'h0000);
      send(ACT_ENQUEUE, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
      send(ACT_ENQUEUE, 16'hFFFF, 16'h0000, 8'h00, 32'h0000_0000, '0);
      send(ACT_ENQUEUE, 16'hFFFF, 16'h0000, 8'h05, 32'd10, '0);
      send(ACT_ENQUEUE, 16'hFFFF, 16'h0001, 8'h00, 32'h0000_0000, '0);
      send(ACT_ENQUEUE, 16'h0000, 16'hFFFF, 8'h80, 32'd7, '0);
      send(ACT_POSITION, 16'hFFFF, 16'h0001, '0, '0, '0);
      send(ACT_COUNT, 16'hFFFF, '0, '0, '0, '0);
      send(ACT_DEQUEUE, 16'hFFFF, '0, '0, '0, '0);
      send(ACT_CANCEL, 16'hFFFF, 16'h0000, '0, '0, '0);
      send(ACT_POSITION, 16'hFFFF, 16'h0001, '0, '0, '0);
      send(ACT_EXPIRE, '0, '0, '0, 32'd5, 16'd1);
      send(ACT_SPARE_A, 16'h1234, '0, '0, '0, '0);
      send(ACT_SPARE_B, 16'h4321, '0, '0, '0, '0);
      send(ACT_EXPIRE, '0, '0, '0, 32'd3601, 16'd1);
      // fill the pool past its limit, then sweep everything in one go
      for (int i = 0; i < 34; i++)
         send(ACT_ENQUEUE, 16'(i % 3), 16'(i), 8'(i % 4), 32'(i), '0);
      send(ACT_EXPIRE, '0, '0, '0, 32'hFFFF_FFFF, '0);
      drain();

      // random traffic, with a calm stretch and a full drain in the middle
      for (int n = 0; n < 500; n++) begin
         if (n == 200) calm = 1;
         if (n == 260) begin
            calm = 0;
            drain();
         end
         random_item();
      end
      drain();
      repeat (3000) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule

// ----- files.f -----
src/kpwq_pkg.sv
src/kpwq_if.sv
src/kpwq_store.sv
src/keyed_priority_wait_queue.sv
verif/kpwq_tb_if.sv
verif/testbench.sv
